@@ rtl/ipdk_pkg.sv @@
// ----------------------------------------------------------------------------
// ipdk_pkg
// Types and constants for the pulse-distance infrared key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ipdk_pkg;

    // Field widths.
    localparam int unsigned TICK_W  = 20;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned CMD_W   = 8;
    localparam int unsigned KEY_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [TICK_W-1:0]  tick_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [KEY_W-1:0]   key_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEADER_MIN     = 3'd0,
        CFG_LEADER_MAX     = 3'd1,
        CFG_ONE_MIN        = 3'd2,
        CFG_ONE_MAX        = 3'd3,
        CFG_MIN_EDGE_COUNT = 3'd4
    } cfg_index_t;

    // Register reset values.
    localparam tick_t  LEADER_MIN_RST     = 20'd10000;
    localparam tick_t  LEADER_MAX_RST     = 20'd14000;
    localparam tick_t  ONE_MIN_RST        = 20'd2000;
    localparam tick_t  ONE_MAX_RST        = 20'd2300;
    localparam count_t MIN_EDGE_COUNT_RST = 6'd36;

    // Item kinds.
    localparam logic KIND_EDGE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    // Edge positions inside a frame.
    localparam count_t LEADER_POS    = 6'd0;
    localparam count_t FIRST_BIT_POS = 6'd17;
    localparam count_t LAST_BIT_POS  = 6'd24;

    // Command codes and their keys.
    localparam cmd_t CMD_KEY1    = 8'd12;
    localparam cmd_t CMD_KEY2    = 8'd24;
    localparam cmd_t CMD_KEY3    = 8'd94;
    localparam cmd_t CMD_INVALID = 8'd255;

    localparam key_t KEY_NONE = 2'd0;
    localparam key_t KEY_1    = 2'd1;
    localparam key_t KEY_2    = 2'd2;
    localparam key_t KEY_3    = 2'd3;

    // Map a command byte to its key code.
    function automatic key_t key_of(input cmd_t cmd);
        key_t k;
        k = KEY_NONE;
        if (cmd == CMD_KEY1)
            k = KEY_1;
        else if (cmd == CMD_KEY2)
            k = KEY_2;
        else if (cmd == CMD_KEY3)
            k = KEY_3;
        return k;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ir_pulse_distance_key_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_distance_key_decoder_unit
// Decodes pulse-distance infrared frames from edge and timeout beats.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------
//  in      | sink      | in_valid / in_stall | kind, interval
//  out     | source    | out_valid/out_stall | frame_ok, command, key
//  cfg     | sink      | cfg_we              | cfg_index, cfg_data
//
// An input beat is captured in the input register and processed from there. A
// result for an accepted timeout beat passes the input register and then the
// output register. One beat is taken every cycle unless in_stall is raised;
// the output register decouples the two sides. A stalled output blocks the
// input only when the waiting beat is a timeout that would produce a new
// result. Reset clears all frame state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_key_decoder_unit
    import ipdk_pkg::*;
#(
    parameter int unsigned MAX_EDGES = 50
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]    cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 kind,
    input  wire logic [TICK_W-1:0]    interval,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      frame_ok,
    output logic [CMD_W-1:0]          command,
    output logic [KEY_W-1:0]          key
);

    localparam count_t MAX_EDGES_C = count_t'(MAX_EDGES);

    // Configuration registers.
    tick_t  leader_min_reg;
    tick_t  leader_max_reg;
    tick_t  one_min_reg;
    tick_t  one_max_reg;
    count_t min_edge_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leader_min_reg     <= LEADER_MIN_RST;
            leader_max_reg     <= LEADER_MAX_RST;
            one_min_reg        <= ONE_MIN_RST;
            one_max_reg        <= ONE_MAX_RST;
            min_edge_count_reg <= MIN_EDGE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEADER_MIN:     leader_min_reg     <= cfg_data;
                CFG_LEADER_MAX:     leader_max_reg     <= cfg_data;
                CFG_ONE_MIN:        one_min_reg        <= cfg_data;
                CFG_ONE_MAX:        one_max_reg        <= cfg_data;
                CFG_MIN_EDGE_COUNT: min_edge_count_reg <= cfg_data[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Input register.
    logic  s1_valid_reg;
    logic  s1_valid_next;
    logic  s1_kind_reg;
    tick_t s1_interval_reg;

    // Frame state.
    logic   armed_reg;
    logic   armed_next;
    count_t edge_count_reg;
    count_t edge_count_next;
    tick_t  leader_reg;
    tick_t  leader_next;
    cmd_t   command_bits_reg;
    cmd_t   command_bits_next;

    // Output register.
    logic out_valid_reg;
    logic out_valid_next;
    logic frame_ok_reg;
    cmd_t command_reg;
    key_t key_reg;

    logic in_fire;
    logic s1_has_result;
    logic s1_go;
    logic s1_fire;
    logic out_free;
    logic frame_good;
    logic bit_one;
    logic [2:0] bit_idx;

    // Handshake control.
    always_comb
    begin
        out_free      = !out_valid_reg || !out_stall;
        s1_has_result = (s1_kind_reg == KIND_TIMEOUT) && armed_reg;
        s1_go         = !s1_has_result || out_free;
        s1_fire       = s1_valid_reg && s1_go;
        in_stall      = s1_valid_reg && !s1_go;
        in_fire       = in_valid && !in_stall;

        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_fire && s1_has_result)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
    end

    // Edge and frame processing.
    always_comb
    begin
        bit_idx    = 3'(edge_count_reg - FIRST_BIT_POS);
        bit_one    = (s1_interval_reg >= one_min_reg) && (s1_interval_reg <= one_max_reg);
        frame_good = (leader_reg >= leader_min_reg) && (leader_reg <= leader_max_reg)
                     && (edge_count_reg >= min_edge_count_reg);

        armed_next        = armed_reg;
        edge_count_next   = edge_count_reg;
        leader_next       = leader_reg;
        command_bits_next = command_bits_reg;

        if (s1_fire)
        begin
            if (s1_kind_reg == KIND_EDGE)
            begin
                if (!armed_reg)
                    armed_next = 1'b1;
                else if (edge_count_reg < MAX_EDGES_C)
                begin
                    if (edge_count_reg == LEADER_POS)
                        leader_next = s1_interval_reg;
                    else if ((edge_count_reg >= FIRST_BIT_POS)
                             && (edge_count_reg <= LAST_BIT_POS) && bit_one)
                        command_bits_next[bit_idx] = 1'b1;
                    edge_count_next = edge_count_reg + count_t'(1);
                end
            end
            else if (armed_reg)
            begin
                armed_next        = 1'b0;
                edge_count_next   = '0;
                leader_next       = '0;
                command_bits_next = '0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            armed_reg        <= 1'b0;
            edge_count_reg   <= '0;
            leader_reg       <= '0;
            command_bits_reg <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
            armed_reg        <= armed_next;
            edge_count_reg   <= edge_count_next;
            leader_reg       <= leader_next;
            command_bits_reg <= command_bits_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg     <= kind;
            s1_interval_reg <= interval;
        end
        if (s1_fire && s1_has_result)
        begin
            frame_ok_reg <= frame_good;
            command_reg  <= frame_good ? command_bits_reg : CMD_INVALID;
            key_reg      <= frame_good ? key_of(command_bits_reg) : KEY_NONE;
        end
    end

    assign out_valid = out_valid_reg;
    assign frame_ok  = frame_ok_reg;
    assign command   = command_reg;
    assign key       = key_reg;

`ifndef NO_ASSERTIONS
    // The edge counter never passes its saturation point.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= MAX_EDGES_C)
        else $error("edge count above limit");

    // An idle decoder holds cleared frame state.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> (edge_count_reg == '0) && (leader_reg == '0)
                       && (command_bits_reg == '0))
        else $error("frame state not cleared while idle");

    // A rejected frame reports the invalid command and no key.
    a_bad_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_ok |-> (command == CMD_INVALID) && (key == KEY_NONE))
        else $error("invalid frame with command or key");

    // A produced result always clears the frame state.
    a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_has_result |=> !armed_reg && out_valid_reg)
        else $error("result did not clear frame");
`endif

endmodule

`default_nettype wire
